### design/npci_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npci_pkg: shared definitions for the nearest palette color index core
// Default palette depth, distance constants and the per-channel helpers.
// ---------------------------------------------------------------------------
package npci_pkg;

  // Default number of palette entries.
  localparam int PAL_ENTRIES_DEFAULT = 125;

  // Running best at the start of a scan; no entry at or above it can win.
  localparam int          BEST_W     = 14;
  localparam logic [13:0] START_BEST = 14'd10000;

  // Weighted distance 2*dr^2 + 4*dg^2 + 3*db^2 stays below 2^20.
  localparam int DIST_W = 20;

  // Request codes carried by the req_type field.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] sq_t;

  // Composite one premultiplied channel over white, saturating at 255.
  function automatic chan_t on_white(input chan_t alpha, input chan_t chan);
    chan_t res;
    if (chan >= alpha) begin
      res = 8'hFF;
    end else begin
      res = 8'hFF - alpha + chan;
    end
    return res;
  endfunction

  // Square of the absolute difference of two channels.
  function automatic sq_t sq_diff(input chan_t a, input chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return sq_t'(d) * sq_t'(d);
  endfunction

endpackage

### design/nearest_palette_color_index_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_palette_color_index_core: nearest palette entry search
// Holds an RGB palette in a synchronous RAM and answers classify beats with
// the index of the closest entry under a weighted squared distance.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries two kinds of beats. A
//   load beat (req_type = 0) writes one palette entry in the cycle it is
//   accepted and produces no output beat; loads at or beyond the palette
//   depth are dropped. A classify beat (req_type = 1) composites the pixel
//   on white and produces exactly one output beat on out_valid / out_ready.
//   A pure white pixel answers with the last palette index without a scan.
//   Any other pixel walks the RAM one entry per cycle: the read port, a
//   squaring stage and a compare stage form a three-deep scan pipeline.
//   The RAM read port sets the scan rate: one entry leaves it each cycle.
//   One beat is in work at a time; in_ready is high whenever no classify is
//   being scanned or held for output, so loads stream at one per cycle and
//   a new beat can be accepted while the previous result still waits in the
//   output register. If the receiver stalls, the finished index waits
//   internally until the output register frees up. Reset clears all control
//   state and the output valid; palette contents are undefined until loaded
//   and need no clearing.
// ---------------------------------------------------------------------------
module nearest_palette_color_index_core #(
  parameter int PALETTE_ENTRIES = npci_pkg::PAL_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [6:0]          in_entry_index,
  input  npci_pkg::chan_t     in_entry_red,
  input  npci_pkg::chan_t     in_entry_green,
  input  npci_pkg::chan_t     in_entry_blue,
  input  npci_pkg::chan_t     in_pixel_alpha,
  input  npci_pkg::chan_t     in_pixel_red,
  input  npci_pkg::chan_t     in_pixel_green,
  input  npci_pkg::chan_t     in_pixel_blue,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_palette_index
);
  import npci_pkg::*;

  localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_ENTRIES - 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  logic [1:0]        state_r,     state_nxt;
  logic [IW-1:0]     scan_addr_r, scan_addr_nxt;
  logic              issue_r,     issue_nxt;
  logic              rd_v_r;
  logic [IW-1:0]     rd_idx_r;
  logic [23:0]       rdata_r;
  logic              sq_v_r;
  logic [IW-1:0]     sq_idx_r;
  sq_t               sqr_r, sqg_r, sqb_r;
  chan_t             pix_r_r, pix_g_r, pix_b_r;
  chan_t             pix_r_nxt, pix_g_nxt, pix_b_nxt;
  logic [BEST_W-1:0] best_r,     best_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_idx_r,   out_idx_nxt;

  // Palette RAM: red in [23:16], green in [15:8], blue in [7:0].
  logic [23:0] pal_mem [PALETTE_ENTRIES];

  // -------------------------------------------------------------------------
  // Input decode
  // -------------------------------------------------------------------------
  logic           in_fire;
  logic           load_in_range;
  logic           wr_en;
  logic [IW+6:0]  wr_addr_ext;
  logic [IW-1:0]  wr_addr;
  chan_t          comp_r, comp_g, comp_b;
  logic           comp_white;
  logic           rd_en;
  logic [DIST_W-1:0] dist_sum;
  logic           dist_wins;
  logic [IW+6:0]  best_idx_ext;

  assign in_ready = (state_r != ST_SCAN) && (state_r != ST_HOLD);
  assign in_fire  = in_valid && in_ready;

  assign load_in_range = (32'(in_entry_index) < 32'(PALETTE_ENTRIES));
  assign wr_en         = in_fire && (in_req_type == REQ_LOAD) && load_in_range;
  assign wr_addr_ext   = {{IW{1'b0}}, in_entry_index};
  assign wr_addr       = wr_addr_ext[IW-1:0];

  assign comp_r     = on_white(in_pixel_alpha, in_pixel_red);
  assign comp_g     = on_white(in_pixel_alpha, in_pixel_green);
  assign comp_b     = on_white(in_pixel_alpha, in_pixel_blue);
  assign comp_white = (comp_r == 8'hFF) && (comp_g == 8'hFF) && (comp_b == 8'hFF);

  // -------------------------------------------------------------------------
  // Palette RAM: one write port for loads, one registered read port for scan.
  // Loads are only taken when no scan runs, so the ports never collide.
  // -------------------------------------------------------------------------
  assign rd_en = (state_r == ST_SCAN) && issue_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[wr_addr] <= {in_entry_red, in_entry_green, in_entry_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= pal_mem[scan_addr_r];
    end
  end

  // -------------------------------------------------------------------------
  // Squaring stage: runs on the entry that left the RAM in the last cycle.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      sq_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
    sq_idx_r <= rd_idx_r;
    sqr_r    <= sq_diff(pix_r_r, rdata_r[23:16]);
    sqg_r    <= sq_diff(pix_g_r, rdata_r[15:8]);
    sqb_r    <= sq_diff(pix_b_r, rdata_r[7:0]);
  end

  // -------------------------------------------------------------------------
  // Compare stage: weighted sum against the running best. Strict less-than
  // keeps the earliest entry on ties.
  // -------------------------------------------------------------------------
  assign dist_sum = DIST_W'({sqr_r, 1'b0}) + DIST_W'({sqg_r, 2'b00})
                  + DIST_W'({sqb_r, 1'b0}) + DIST_W'(sqb_r);
  assign dist_wins = sq_v_r && (dist_sum < DIST_W'(best_r));

  assign best_idx_ext = {7'd0, best_idx_r};

  // -------------------------------------------------------------------------
  // Controller
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    pix_r_nxt     = pix_r_r;
    pix_g_nxt     = pix_g_r;
    pix_b_nxt     = pix_b_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_req_type == REQ_CLASSIFY)) begin
          pix_r_nxt     = comp_r;
          pix_g_nxt     = comp_g;
          pix_b_nxt     = comp_b;
          best_nxt      = START_BEST;
          scan_addr_nxt = '0;
          if (comp_white) begin
            // Pure white skips the scan and answers with the last entry.
            best_idx_nxt = LAST_IDX;
            state_nxt    = ST_HOLD;
          end else begin
            best_idx_nxt = '0;
            issue_nxt    = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          if (scan_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        if (dist_wins) begin
          best_nxt     = BEST_W'(dist_sum);
          best_idx_nxt = sq_idx_r;
        end
        if (sq_v_r && (sq_idx_r == LAST_IDX)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = best_idx_ext[6:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        issue_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    pix_r_r     <= pix_r_nxt;
    pix_g_r     <= pix_g_nxt;
    pix_b_r     <= pix_b_nxt;
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = out_idx_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // A new result only appears after the controller held a finished answer.
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_HOLD))
    else $error("output beat raised without a finished search");

  // The scan pipeline is empty whenever the block is idle.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_v_r && !sq_v_r && !issue_r))
    else $error("scan pipeline active while idle");

  // The running best never climbs above its starting value during a scan.
  a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (best_r <= START_BEST))
    else $error("running best above start value");

  // A white classify beat goes straight to the result with the last index.
  a_white_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_req_type == REQ_CLASSIFY) && comp_white)
      |=> ((state_r == ST_HOLD) && (best_idx_r == LAST_IDX)))
    else $error("white pixel did not take the shortcut");

  // No RAM write can land while a scan is reading the palette.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !wr_en)
    else $error("palette write during scan");

endmodule

### test/nearest_palette_color_index_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_palette_color_index_checker: palette search scoreboard
// Mirrors accepted in-range loads into a private palette, predicts the index
// for every accepted classify beat and compares it with the result channel.
// ---------------------------------------------------------------------------
module nearest_palette_color_index_checker #(
  parameter int PALETTE_ENTRIES = npci_pkg::PAL_ENTRIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            in_req_type,
  input  logic [6:0]      in_entry_index,
  input  npci_pkg::chan_t in_entry_red,
  input  npci_pkg::chan_t in_entry_green,
  input  npci_pkg::chan_t in_entry_blue,
  input  npci_pkg::chan_t in_pixel_alpha,
  input  npci_pkg::chan_t in_pixel_red,
  input  npci_pkg::chan_t in_pixel_green,
  input  npci_pkg::chan_t in_pixel_blue,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [6:0]      out_palette_index,
  output int              mismatches,
  output int              pending
);

  typedef struct packed {
    npci_pkg::chan_t red;
    npci_pkg::chan_t green;
    npci_pkg::chan_t blue;
  } rgb_t;

  rgb_t       palette_copy [PALETTE_ENTRIES];
  logic [6:0] pending_answers [$];
  int         error_total = 0;

  // Premultiplied channel laid over a white background, clipped at full scale.
  function automatic int over_white(input npci_pkg::chan_t alpha, input npci_pkg::chan_t chan);
    int v;
    v = 255 - int'(alpha) + int'(chan);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic logic [6:0] nearest_index(input int r, input int g, input int b);
    int best;
    int best_at;
    int dist_sum;
    int dr;
    int dg;
    int db;
    if (r == 255 && g == 255 && b == 255) begin
      return 7'(PALETTE_ENTRIES - 1);
    end
    best    = int'(npci_pkg::START_BEST);
    best_at = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr       = r - int'(palette_copy[i].red);
      dg       = g - int'(palette_copy[i].green);
      db       = b - int'(palette_copy[i].blue);
      dist_sum = 2 * dr * dr + 4 * dg * dg + 3 * db * db;
      // Only a strictly smaller distance takes over, so ties keep the lower index.
      if (dist_sum < best) begin
        best    = dist_sum;
        best_at = i;
      end
    end
    return 7'(best_at);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_total++;
  endtask

  always @(posedge clk) begin : track
    logic [6:0] want;
    if (!rst_n) begin
      pending_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result index %0d with no classify beat waiting",
                                    out_palette_index));
        end else begin
          want = pending_answers.pop_front();
          if (out_palette_index !== want) begin
            report_mismatch($sformatf("palette_index %0d, expected %0d",
                                      out_palette_index, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req_type == npci_pkg::REQ_LOAD) begin
          if (in_entry_index < PALETTE_ENTRIES) begin
            palette_copy[in_entry_index] = {in_entry_red, in_entry_green, in_entry_blue};
          end
        end else begin
          pending_answers.push_back(nearest_index(over_white(in_pixel_alpha, in_pixel_red),
                                                  over_white(in_pixel_alpha, in_pixel_green),
                                                  over_white(in_pixel_alpha, in_pixel_blue)));
        end
      end
    end
    mismatches <= error_total;
    pending    <= pending_answers.size();
  end

endmodule

### test/tb_nearest_palette_color_index_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_palette_color_index_core: stimulus and verdict for the core
// Loads whole palettes of several shapes, classifies directed and random
// pixels, and lets the checker beside the core predict and compare results.
// ---------------------------------------------------------------------------
module tb_nearest_palette_color_index_core;

  import npci_pkg::*;

  localparam int PAL_ENTRIES = PAL_ENTRIES_DEFAULT;
  // Cycles without any accepted beat on either channel before giving up. A
  // classify scan and the longest receiver hold-off both stay far below this,
  // so a healthy run never comes close to it.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  // Margin after the last expected result, a little over one full scan.
  localparam int DRAIN_CYCLES = 140;

  typedef enum {PAL_GRID, PAL_SCATTER, PAL_DARK, PAL_REPEATS} palette_style_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_req_type;
  logic [6:0] in_entry_index;
  chan_t      in_entry_red;
  chan_t      in_entry_green;
  chan_t      in_entry_blue;
  chan_t      in_pixel_alpha;
  chan_t      in_pixel_red;
  chan_t      in_pixel_green;
  chan_t      in_pixel_blue;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_palette_index;

  int mismatches;
  int pending;

  // Shared between the stimulus and the receiver: no_idle switches off random
  // gaps on both sides, hold_request asks the receiver for one long hold-off.
  logic no_idle;
  logic hold_request;

  // What the stimulus has loaded so far; used only to aim pixels near entries.
  chan_t loaded_red   [PAL_ENTRIES];
  chan_t loaded_green [PAL_ENTRIES];
  chan_t loaded_blue  [PAL_ENTRIES];

  // The five levels of a 5x5x5 color cube, the palette this core is built for.
  chan_t grid_level [5] = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};

  nearest_palette_color_index_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_entry_red      (in_entry_red),
    .in_entry_green    (in_entry_green),
    .in_entry_blue     (in_entry_blue),
    .in_pixel_alpha    (in_pixel_alpha),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index)
  );

  nearest_palette_color_index_checker #(
    .PALETTE_ENTRIES (PAL_ENTRIES)
  ) chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_entry_index    (in_entry_index),
    .in_entry_red      (in_entry_red),
    .in_entry_green    (in_entry_green),
    .in_entry_blue     (in_entry_blue),
    .in_pixel_alpha    (in_pixel_alpha),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one beat and returns in the time step of the edge that accepts it.
  // A random gap may come first; when beats follow each other with no gap,
  // in_valid is simply left high, so it never drops and rises in one step.
  task automatic send_beat(input logic kind, input logic [6:0] idx,
                           input chan_t er, input chan_t eg, input chan_t eb,
                           input chan_t pa, input chan_t pr, input chan_t pg,
                           input chan_t pb);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_entry_index <= idx;
    in_entry_red   <= er;
    in_entry_green <= eg;
    in_entry_blue  <= eb;
    in_pixel_alpha <= pa;
    in_pixel_red   <= pr;
    in_pixel_green <= pg;
    in_pixel_blue  <= pb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Load beat; the unused pixel fields carry noise that the core must ignore.
  task automatic send_load(input logic [6:0] idx, input chan_t r, input chan_t g,
                           input chan_t b);
    if (idx < PAL_ENTRIES) begin
      loaded_red[idx]   = r;
      loaded_green[idx] = g;
      loaded_blue[idx]  = b;
    end
    send_beat(REQ_LOAD, idx, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // Classify beat; the unused entry fields carry noise as well.
  task automatic send_classify(input chan_t a, input chan_t r, input chan_t g,
                               input chan_t b);
    send_beat(REQ_CLASSIFY, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              a, r, g, b);
  endtask

  // Writes every palette entry once, starting at a random slot and wrapping,
  // with the odd out-of-range load mixed in. Classify beats that scan are only
  // sent after the first such fill, so no scan ever reads an unwritten entry.
  task automatic fill_palette(input palette_style_t style);
    chan_t few_red   [6];
    chan_t few_green [6];
    chan_t few_blue  [6];
    int    offset;
    int    slot;
    int    k;
    offset = $urandom_range(0, PAL_ENTRIES - 1);
    foreach (few_red[j]) begin
      few_red[j]   = 8'($urandom);
      few_green[j] = 8'($urandom);
      few_blue[j]  = 8'($urandom);
    end
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      slot = (i + offset) % PAL_ENTRIES;
      if ($urandom_range(99) < 4) begin
        send_load(7'($urandom_range(PAL_ENTRIES, 127)), 8'($urandom), 8'($urandom),
                  8'($urandom));
      end
      case (style)
        PAL_GRID: begin
          send_load(7'(slot), grid_level[slot / 25], grid_level[(slot / 5) % 5],
                    grid_level[slot % 5]);
        end
        PAL_SCATTER: begin
          send_load(7'(slot), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        PAL_DARK: begin
          // A tight cluster near black: bright pixels find nothing under the
          // starting best and must fall back to index 0.
          send_load(7'(slot), 8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                    8'($urandom_range(0, 31)));
        end
        default: begin
          // Only six distinct colors, so exact ties between entries are common.
          k = $urandom_range(0, 5);
          send_load(7'(slot), few_red[k], few_green[k], few_blue[k]);
        end
      endcase
    end
  endtask

  // Moves a channel a few steps away from a palette color, clipped to 0..255.
  function automatic chan_t jitter(input chan_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return chan_t'(v);
  endfunction

  // Receiver: drops out_ready at random, not at all while no_idle is set, and
  // once, on hold_request, holds it low through one whole hold-off so that a
  // finished result backs up and the core stops taking input.
  initial begin : receiver
    int  hold_left;
    bit  hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    chan_t a;
    chan_t r;
    chan_t g;
    chan_t b;
    int    e;
    int    pick;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_LOAD;
    in_entry_index <= '0;
    in_entry_red   <= '0;
    in_entry_green <= '0;
    in_entry_blue  <= '0;
    in_pixel_alpha <= '0;
    in_pixel_red   <= '0;
    in_pixel_green <= '0;
    in_pixel_blue  <= '0;
    no_idle        <= 1'b0;
    hold_request   <= 1'b0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any entry exists only the white shortcut may be exercised: a fully
    // transparent pixel, and one whose channels exceed alpha and clip to white.
    // A load past the end of the palette must leave nothing behind either.
    send_classify(8'd0, 8'd0, 8'd0, 8'd0);
    send_classify(8'd10, 8'd200, 8'd200, 8'd200);
    send_load(7'd127, 8'hFF, 8'hFF, 8'hFF);

    // Directed part on the 5x5x5 cube, where the answers are easy to reason
    // about: entry index = 25*red_level + 5*green_level + blue_level.
    fill_palette(PAL_GRID);
    send_classify(8'd255, 8'd0, 8'd0, 8'd0);        // black, exact hit on entry 0
    send_classify(8'd255, 8'd255, 8'd0, 8'd0);      // pure red
    send_classify(8'd128, 8'd0, 8'd0, 8'd0);        // half alpha composites to mid gray
    send_classify(8'd100, 8'd200, 8'd0, 8'd50);     // red above alpha saturates
    send_classify(8'd255, 8'd254, 8'd255, 8'd255);  // next to white, still scanned
    send_classify(8'd255, 8'd255, 8'd255, 8'd255);  // opaque white shortcut
    send_classify(8'd0, 8'd255, 8'd255, 8'd255);    // transparent, channels at maximum
    send_classify(8'd1, 8'd0, 8'd0, 8'd0);          // nearly transparent, not white
    send_load(7'd125, 8'd1, 8'd2, 8'd3);            // first index past the end
    send_classify(8'd255, 8'd1, 8'd2, 8'd3);
    // Entry 0 turned white ties with the last entry; the lower index must win.
    send_load(7'd0, 8'd255, 8'd255, 8'd255);
    send_classify(8'd255, 8'd254, 8'd255, 8'd255);
    send_load(7'd0, 8'd0, 8'd0, 8'd0);
    // Two exact copies of entry 3 further up must not take over from it.
    send_load(7'd60, 8'd0, 8'd0, 8'd192);
    send_load(7'd124, 8'd0, 8'd0, 8'd192);
    send_classify(8'd255, 8'd0, 8'd0, 8'd192);
    send_classify(8'd255, 8'd0, 8'd0, 8'd190);
    send_load(7'd124, 8'd255, 8'd255, 8'd255);

    // Random rounds, each on a freshly filled palette of a different shape.
    // The dark round runs with no gaps on either side; the round with repeated
    // colors carries the long receiver hold-off.
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          fill_palette(PAL_SCATTER);
        end
        1: begin
          no_idle <= 1'b1;
          fill_palette(PAL_DARK);
        end
        default: begin
          no_idle <= 1'b0;
          fill_palette(PAL_REPEATS);
        end
      endcase
      for (int n = 0; n < 40; n++) begin
        if (round == 2 && n == 10) begin
          hold_request <= 1'b1;
        end
        if ($urandom_range(99) < 18) begin
          // Stray loads, out-of-range indexes included.
          send_load(7'($urandom_range(0, 127)), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end else begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            // Opaque pixel just off a loaded color: small distances and ties.
            e = $urandom_range(0, PAL_ENTRIES - 1);
            a = 8'd255;
            r = jitter(loaded_red[e]);
            g = jitter(loaded_green[e]);
            b = jitter(loaded_blue[e]);
          end else if (pick < 70) begin
            // Well-formed premultiplied pixel, every channel at most alpha.
            a = 8'($urandom_range(0, 255));
            r = 8'($urandom_range(0, a));
            g = 8'($urandom_range(0, a));
            b = 8'($urandom_range(0, a));
          end else if (pick < 80) begin
            // Malformed pixel: channels may exceed alpha and clip.
            a = 8'($urandom_range(0, 200));
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
          end else if (pick < 92) begin
            a = 8'd255;
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
          end else begin
            // Channels equal to alpha composite to white; blue sometimes breaks it.
            a = 8'($urandom);
            r = a;
            g = a;
            b = $urandom_range(0, 1) ? a : 8'($urandom);
          end
          send_classify(a, r, g, b);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // Give a misbehaving core time to emit a stray extra result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    // Every classify beat must have been answered by now.
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
